/* rtl/core/event_interval_burst_monitor_macros.svh */
// Assertion macros shared by the event interval burst monitor.
`ifndef EVENT_INTERVAL_BURST_MONITOR_MACROS_SVH
`define EVENT_INTERVAL_BURST_MONITOR_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define EIBM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define EIBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/eibm_pkg.sv */
// Types, constants and helpers of the event interval burst monitor.
package eibm_pkg;

  localparam int unsigned NUM_REGS   = 4;
  localparam int unsigned READ_SLOTS = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned TIME_W     = 64;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [TIME_W-1:0] time_t;

  localparam cnt_t CNT_SAT = 32'hFFFF_FFFF;

  localparam cnt_t THR_RESET [NUM_REGS] = '{32'd1000, 32'd10000, 32'd100000, 32'd1000000};

  typedef enum logic {
    ACT_RECORD = 1'b0,
    ACT_READ   = 1'b1
  } action_t;

  typedef struct packed {
    logic rec_en;
    logic adm;
    logic last_adm;
  } rec_ctl_t;

  typedef struct packed {
    time_t since_any;
    time_t since_susp;
    time_t overall;
  } interval_t;

  typedef struct packed {
    cnt_t short_total;
    cnt_t adm_total;
    cnt_t susp_total;
    cnt_t run_max;
    cnt_t adm_run_max;
    cnt_t susp_run_max;
  } level_stats_t;

  // Interval is short when it lies below the 32-bit threshold.
  function automatic logic below_thr(time_t iv, cnt_t thr);
    return (iv[TIME_W-1:CNT_W] == '0) && (iv[CNT_W-1:0] < thr);
  endfunction

endpackage

/* rtl/core/event_interval_burst_monitor.sv */
// Event interval burst monitor. Throughput one word per cycle while the result
// channel is not stalled; an accepted word is registered, then all level
// updates and the result are formed in one pass into the output register.
// A stalled output holds one result while one more word waits in the input register.
// Synchronous active-high rst clears all counters, runs, maxima and timestamps
// and loads the threshold reset values; no clearing pass is needed.
module event_interval_burst_monitor #(
  parameter int unsigned LEVELS = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [eibm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [eibm_pkg::CNT_W-1:0]         cfg_data,
  // input channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               action,
  input  logic [eibm_pkg::TIME_W-1:0]        event_time,
  input  logic                               admitted,
  input  logic [1:0]                         level_index,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [3:0]                         short_hit_mask,
  output logic [3:0]                         suspicious_hit_mask,
  output logic [eibm_pkg::CNT_W-1:0]         short_count,
  output logic [eibm_pkg::CNT_W-1:0]         admitted_short_count,
  output logic [eibm_pkg::CNT_W-1:0]         suspicious_short_count,
  output logic [eibm_pkg::CNT_W-1:0]         longest_run,
  output logic [eibm_pkg::CNT_W-1:0]         longest_admitted_run,
  output logic [eibm_pkg::CNT_W-1:0]         longest_suspicious_run
);

  // ---------------------------------------------------------------------------
  // Thresholds: one register per level that has a configuration index;
  // higher levels compare against zero and so never count.
  // ---------------------------------------------------------------------------
  eibm_pkg::cnt_t thr [LEVELS];

  for (genvar l = 0; l < LEVELS; l++) begin : g_thr
    if (l < eibm_pkg::NUM_REGS) begin : g_reg
      always_ff @(posedge clk) begin
        if (rst) begin
          thr[l] <= eibm_pkg::THR_RESET[l];
        end else if (cfg_we && (cfg_index == eibm_pkg::CFG_IDX_W'(l))) begin
          thr[l] <= cfg_data;
        end
      end
    end else begin : g_zero
      assign thr[l] = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Input register: holds one word until the result register can take it.
  // ---------------------------------------------------------------------------
  logic              in_vld;
  eibm_pkg::action_t act_q;
  eibm_pkg::time_t   time_q;
  logic              adm_q;
  logic [1:0]        lvl_q;
  logic              advance;

  assign advance  = in_vld && (!out_valid || out_ready);
  assign in_ready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ready) begin
      in_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      act_q  <= eibm_pkg::action_t'(action);
      time_q <= event_time;
      adm_q  <= admitted;
      lvl_q  <= level_index;
    end
  end

  // ---------------------------------------------------------------------------
  // Single pass: intervals, then all levels in parallel.
  // State updates at the same edge that moves the word to the result register,
  // so the next word always sees the state this one left.
  // ---------------------------------------------------------------------------
  eibm_pkg::interval_t    iv;
  logic                   last_adm;
  eibm_pkg::rec_ctl_t     ctl;
  logic [LEVELS-1:0]      short_hit;
  logic [LEVELS-1:0]      susp_hit;
  eibm_pkg::level_stats_t stats [LEVELS];

  assign ctl.rec_en   = advance && (act_q == eibm_pkg::ACT_RECORD);
  assign ctl.adm      = adm_q;
  assign ctl.last_adm = last_adm;

  eibm_interval u_interval (
    .clk      (clk),
    .rst      (rst),
    .rec_en   (ctl.rec_en),
    .adm      (adm_q),
    .now      (time_q),
    .iv       (iv),
    .last_adm (last_adm)
  );

  for (genvar l = 0; l < LEVELS; l++) begin : g_level
    eibm_level u_level (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .iv        (iv),
      .thr       (thr[l]),
      .short_hit (short_hit[l]),
      .susp_hit  (susp_hit[l]),
      .stats     (stats[l])
    );
  end

  // Map levels onto the four visible mask bits and read slots; slots past
  // the last level read as zero.
  logic [eibm_pkg::READ_SLOTS-1:0] short_mask_c;
  logic [eibm_pkg::READ_SLOTS-1:0] susp_mask_c;
  eibm_pkg::level_stats_t          rd_slot [eibm_pkg::READ_SLOTS];
  eibm_pkg::level_stats_t          rd_sel;

  for (genvar s = 0; s < eibm_pkg::READ_SLOTS; s++) begin : g_slot
    if (s < LEVELS) begin : g_live
      assign short_mask_c[s] = short_hit[s];
      assign susp_mask_c[s]  = susp_hit[s];
      assign rd_slot[s]      = stats[s];
    end else begin : g_none
      assign short_mask_c[s] = 1'b0;
      assign susp_mask_c[s]  = 1'b0;
      assign rd_slot[s]      = '0;
    end
  end

  assign rd_sel = rd_slot[lvl_q];

  // ---------------------------------------------------------------------------
  // Result register: a record shows only masks, a read only counters.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (act_q == eibm_pkg::ACT_READ) begin
        short_hit_mask         <= '0;
        suspicious_hit_mask    <= '0;
        short_count            <= rd_sel.short_total;
        admitted_short_count   <= rd_sel.adm_total;
        suspicious_short_count <= rd_sel.susp_total;
        longest_run            <= rd_sel.run_max;
        longest_admitted_run   <= rd_sel.adm_run_max;
        longest_suspicious_run <= rd_sel.susp_run_max;
      end else begin
        short_hit_mask         <= short_mask_c;
        suspicious_hit_mask    <= susp_mask_c;
        short_count            <= '0;
        admitted_short_count   <= '0;
        suspicious_short_count <= '0;
        longest_run            <= '0;
        longest_admitted_run   <= '0;
        longest_suspicious_run <= '0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `include "event_interval_burst_monitor_macros.svh"

  `EIBM_ASSERT_NOW(a_backpressure_only_when_full, !in_ready,
                   in_vld && out_valid && !out_ready, "input stalled while a stage is free")
  `EIBM_ASSERT_NEXT(a_read_has_no_hits, advance && (act_q == eibm_pkg::ACT_READ),
                    (short_hit_mask == '0) && (suspicious_hit_mask == '0),
                    "read result carries hit bits")
  `EIBM_ASSERT_NEXT(a_record_has_no_counts, ctl.rec_en,
                    (short_count == '0) && (longest_run == '0) && (longest_suspicious_run == '0),
                    "record result carries counters")
  `EIBM_ASSERT_NEXT(a_admitted_no_susp_hit, ctl.rec_en && adm_q, suspicious_hit_mask == '0,
                    "admitted word set a suspicious hit")

endmodule

/* rtl/core/eibm_interval.sv */
// Timestamp state and the three intervals of each event.
module eibm_interval (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   rec_en,
  input  logic                   adm,
  input  eibm_pkg::time_t        now,
  output eibm_pkg::interval_t    iv,
  output logic                   last_adm
);

  eibm_pkg::time_t last_event_time;
  eibm_pkg::time_t last_susp_time;

  always_comb begin
    iv.since_any  = now - last_event_time;
    iv.since_susp = now - last_susp_time;
    iv.overall    = (iv.since_any < iv.since_susp) ? iv.since_any : iv.since_susp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_event_time <= '0;
      last_susp_time  <= '0;
      last_adm        <= 1'b0;
    end else if (rec_en) begin
      last_event_time <= now;
      if (!adm) begin
        last_susp_time <= now;
      end
      last_adm <= adm;
    end
  end

endmodule

/* rtl/core/eibm_level.sv */
// Counters, runs and run maxima of one threshold level.
module eibm_level (
  input  logic                    clk,
  input  logic                    rst,
  input  eibm_pkg::rec_ctl_t      ctl,
  input  eibm_pkg::interval_t     iv,
  input  eibm_pkg::cnt_t          thr,
  output logic                    short_hit,
  output logic                    susp_hit,
  output eibm_pkg::level_stats_t  stats
);

  eibm_pkg::cnt_t run;
  eibm_pkg::cnt_t adm_run;
  eibm_pkg::cnt_t susp_run;

  logic short_ov;
  logic short_any;
  logic short_susp;

  assign short_ov   = eibm_pkg::below_thr(iv.overall, thr);
  assign short_any  = eibm_pkg::below_thr(iv.since_any, thr);
  assign short_susp = eibm_pkg::below_thr(iv.since_susp, thr);

  assign short_hit = short_ov && (stats.short_total != eibm_pkg::CNT_SAT);
  assign susp_hit  = !ctl.adm && short_susp && (stats.susp_total != eibm_pkg::CNT_SAT);

  always_ff @(posedge clk) begin
    if (rst) begin
      run      <= '0;
      adm_run  <= '0;
      susp_run <= '0;
      stats    <= '0;
    end else if (ctl.rec_en) begin
      // overall interval
      if (short_ov) begin
        if (short_hit) begin
          stats.short_total <= stats.short_total + 1'b1;
          if (run != eibm_pkg::CNT_SAT) begin
            run <= run + 1'b1;
            if (run >= stats.run_max) begin
              stats.run_max <= run + 1'b1;
            end
          end
        end
      end else begin
        run <= '0;
      end
      // admitted or suspicious interval
      if (ctl.adm) begin
        if (short_any) begin
          if (stats.adm_total != eibm_pkg::CNT_SAT) begin
            stats.adm_total <= stats.adm_total + 1'b1;
            if (!ctl.last_adm) begin
              adm_run <= '0;
            end else if (adm_run != eibm_pkg::CNT_SAT) begin
              adm_run <= adm_run + 1'b1;
              if (adm_run >= stats.adm_run_max) begin
                stats.adm_run_max <= adm_run + 1'b1;
              end
            end
          end
        end else begin
          adm_run <= '0;
        end
      end else begin
        if (short_susp) begin
          if (susp_hit) begin
            stats.susp_total <= stats.susp_total + 1'b1;
            if (ctl.last_adm) begin
              susp_run <= '0;
            end else if (susp_run != eibm_pkg::CNT_SAT) begin
              susp_run <= susp_run + 1'b1;
              if (susp_run >= stats.susp_run_max) begin
                stats.susp_run_max <= susp_run + 1'b1;
              end
            end
          end
        end else begin
          susp_run <= '0;
        end
      end
    end
  end

endmodule
